[hdl/ihd_pkg.sv]
// Shared types and constants for the impact hit detector.
`timescale 1ns / 1ps
package ihd_pkg;
    localparam int SAMPLE_BITS  = 24;
    localparam int HP_BITS      = SAMPLE_BITS + 1;
    localparam int SUM_BITS     = HP_BITS + 2;
    localparam int DSUM_BITS    = SUM_BITS + 1;
    localparam int DCH_BITS     = HP_BITS + 1;
    localparam int DELAY_SLOTS  = 64;
    localparam int WINDOW_SLOTS = 64;
    localparam int DA_BITS      = $clog2(DELAY_SLOTS);
    localparam int WA_BITS      = $clog2(WINDOW_SLOTS);
    localparam int DW_BITS      = SUM_BITS + 4 * HP_BITS;
    localparam int WW_BITS      = DSUM_BITS + 4 * DCH_BITS;
    localparam int REFR_MUL     = 3906;
    localparam int RECIP_125    = 8589935;
    localparam int RECIP_SHIFT  = 30;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_SHIFT  = 3'd0;
    localparam logic [2:0] REG_THRESH = 3'd1;
    localparam logic [2:0] REG_MINDUR = 3'd2;
    localparam logic [2:0] REG_REFR   = 3'd3;
    localparam logic [2:0] REG_SETTLE = 3'd4;
    localparam logic [2:0] REG_DDEPTH = 3'd5;
    localparam logic [2:0] REG_WDEPTH = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_DIFF, ST_SCAN, ST_TAIL, ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0, MODE_ARMED = 2'd1, MODE_REFR = 2'd2, MODE_SETTLE = 2'd3
    } t_mode;

    typedef struct packed {
        logic capture;
        logic load;
        logic diff;
        logic scan_rd;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic fire;
        logic scan_last;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [4:0]  baseline_shift;
        logic [28:0] hit_threshold;
        logic [15:0] min_duration;
        logic [15:0] refr_samples;
        logic [15:0] settle_samples;
        logic [6:0]  diff_depth;
        logic [6:0]  window_depth;
    } t_cfg;
endpackage

[hdl/ihd_ctrl.sv]
// Sequencing state machine for the impact hit detector.
`timescale 1ns / 1ps
module ihd_ctrl import ihd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state = i_sts.fire ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) n_state = ST_TAIL;
            end
            ST_TAIL: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

[hdl/ihd_dp.sv]
// Datapath: baselines, delay line, window ring, detector and result register.
`timescale 1ns / 1ps
module ihd_dp import ihd_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cfg                        i_cfg,
    input  t_cmd                        i_cmd,
    output t_sts                        o_sts,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_ch0,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_ch1,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_ch2,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_ch3,
    input  logic [31:0]                 i_time_ms,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic signed [27:0]          o_hp_sum,
    output logic signed [28:0]          o_diff_sum,
    output logic                        o_event_valid,
    output logic [28:0]                 o_event_peak,
    output logic [26:0]                 o_peak_ch0,
    output logic [26:0]                 o_peak_ch1,
    output logic [26:0]                 o_peak_ch2,
    output logic [26:0]                 o_peak_ch3,
    output logic [31:0]                 o_event_time_ms,
    output logic [1:0]                  o_detector_state
);
    logic signed [SAMPLE_BITS-1:0] r_x [4];
    logic [31:0]                   r_time;
    logic signed [SAMPLE_BITS-1:0] r_base [4];
    logic signed [HP_BITS-1:0]     r_hp [4];
    logic signed [SUM_BITS-1:0]    r_sum;
    logic [DW_BITS-1:0]            r_dly_mem [DELAY_SLOTS];
    logic [DW_BITS-1:0]            r_dly_rd;
    logic [WW_BITS-1:0]            r_win_mem [WINDOW_SLOTS];
    logic [WW_BITS-1:0]            r_win_rd;
    logic [DA_BITS-1:0]            r_dly_ptr;
    logic [DA_BITS:0]              r_dly_fill;
    logic [WA_BITS-1:0]            r_win_ptr;
    logic [WA_BITS:0]              r_win_fill;
    logic                          r_have;
    logic signed [DSUM_BITS-1:0]   r_dsum;
    t_mode                         r_mode;
    logic [15:0]                   r_run, r_refr, r_settle;
    logic                          r_fired;
    logic [WA_BITS-1:0]            r_scan_p;
    logic [WA_BITS:0]              r_scan_j;
    logic                          r_cmp_v;
    logic [28:0]                   r_pk;
    logic [26:0]                   r_pch [4];

    logic signed [SAMPLE_BITS:0]   w_d [4];
    logic signed [SAMPLE_BITS-1:0] w_bnew [4];
    logic signed [HP_BITS-1:0]     w_hp [4];
    logic signed [SUM_BITS-1:0]    w_sum;
    logic [DA_BITS:0]              w_dd;
    logic [WA_BITS:0]              w_wd;
    logic [DA_BITS-1:0]            w_old;
    logic signed [DSUM_BITS-1:0]   w_dsum;
    logic signed [DCH_BITS-1:0]    w_dch [4];
    logic [WA_BITS-1:0]            w_widx;
    logic [WA_BITS:0]              w_winc;
    logic [DSUM_BITS-1:0]          w_adif;
    logic                          w_above;
    logic [15:0]                   w_run_inc;
    logic signed [DSUM_BITS-1:0]   w_rsum;
    logic signed [DCH_BITS-1:0]    w_rch [4];
    logic [28:0]                   w_rsmag;
    logic [26:0]                   w_rcmag [4];

    // Baseline update and high-pass values.
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < 4; i++) begin
            w_d[i]    = {r_x[i][SAMPLE_BITS-1], r_x[i]} - {r_base[i][SAMPLE_BITS-1], r_base[i]};
            w_bnew[i] = SAMPLE_BITS'(r_base[i] + SAMPLE_BITS'(w_d[i] >>> i_cfg.baseline_shift));
            w_hp[i]   = HP_BITS'(r_x[i]) - HP_BITS'(w_bnew[i]);
            w_sum     = w_sum + SUM_BITS'(w_hp[i]);
        end
    end

    // Depth clamps and delay read address.
    always_comb begin
        w_dd = (i_cfg.diff_depth == '0) ? (DA_BITS+1)'(1) :
               (i_cfg.diff_depth > 7'(DELAY_SLOTS)) ? (DA_BITS+1)'(DELAY_SLOTS) :
               (DA_BITS+1)'(i_cfg.diff_depth);
        w_wd = (i_cfg.window_depth == '0) ? (WA_BITS+1)'(1) :
               (i_cfg.window_depth > 7'(WINDOW_SLOTS)) ? (WA_BITS+1)'(WINDOW_SLOTS) :
               (WA_BITS+1)'(i_cfg.window_depth);
        w_old  = DA_BITS'({1'b0, r_dly_ptr} + (DA_BITS+1)'(DELAY_SLOTS) - w_dd);
        w_widx = ({1'b0, r_win_ptr} < w_wd) ? r_win_ptr : '0;
        w_winc = {1'b0, w_widx} + 1'b1;
    end

    // Differences against the delayed values.
    always_comb begin
        w_dsum = r_have ? DSUM_BITS'(r_sum) - DSUM_BITS'($signed(r_dly_rd[DW_BITS-1 -: SUM_BITS]))
                        : '0;
        for (int i = 0; i < 4; i++) begin
            w_dch[i] = r_have ? DCH_BITS'(r_hp[i]) -
                                DCH_BITS'($signed(r_dly_rd[i*HP_BITS +: HP_BITS])) : '0;
        end
        w_adif    = w_dsum[DSUM_BITS-1] ? DSUM_BITS'(-w_dsum) : DSUM_BITS'(w_dsum);
        w_above   = {1'b0, w_adif} >= i_cfg.hit_threshold;
        w_run_inc = (r_run == 16'hFFFF) ? r_run : r_run + 16'd1;
    end

    // Magnitudes of the window word being scanned.
    always_comb begin
        w_rsum  = $signed(r_win_rd[WW_BITS-1 -: DSUM_BITS]);
        w_rsmag = 29'(w_rsum[DSUM_BITS-1] ? -w_rsum : w_rsum);
        for (int i = 0; i < 4; i++) begin
            w_rch[i]   = $signed(r_win_rd[i*DCH_BITS +: DCH_BITS]);
            w_rcmag[i] = 27'(w_rch[i][DCH_BITS-1] ? -w_rch[i] : w_rch[i]);
        end
    end

    // Status back to the controller.
    always_comb begin
        o_sts.fire      = (r_mode == MODE_ARMED) && w_above &&
                          (w_run_inc >= i_cfg.min_duration);
        o_sts.scan_last = (r_scan_j == r_win_fill - 1'b1);
        o_sts.out_free  = !o_out_valid || !i_out_stall;
    end

    // Input capture and per-item working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x[0] <= i_sample_ch0;
            r_x[1] <= i_sample_ch1;
            r_x[2] <= i_sample_ch2;
            r_x[3] <= i_sample_ch3;
            r_time <= i_time_ms;
        end
        if (i_cmd.load) begin
            r_hp  <= w_hp;
            r_sum <= w_sum;
        end
        if (i_cmd.diff) begin
            r_dsum <= w_dsum;
        end
    end

    // Delay line memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dly_rd <= r_dly_mem[w_old];
        end
        if (i_cmd.diff) begin
            r_dly_mem[r_dly_ptr] <= {r_sum, r_hp[3], r_hp[2], r_hp[1], r_hp[0]};
        end
    end

    // Window ring memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_win_mem[w_widx] <= {w_dsum, w_dch[3], w_dch[2], w_dch[1], w_dch[0]};
        end
        if (i_cmd.scan_rd) begin
            r_win_rd <= r_win_mem[r_scan_p];
        end
    end

    // Baselines, pointers, fill counts and detector state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_base[i] <= '0;
            r_dly_ptr  <= '0;
            r_dly_fill <= '0;
            r_win_ptr  <= '0;
            r_win_fill <= '0;
            r_have     <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_run      <= '0;
            r_refr     <= '0;
            r_settle   <= '0;
            r_fired    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_base <= w_bnew;
                r_have <= (r_dly_fill >= w_dd);
            end
            if (i_cmd.diff) begin
                r_dly_ptr <= r_dly_ptr + 1'b1;
                if (!r_have) r_dly_fill <= r_dly_fill + 1'b1;
                r_win_ptr  <= (w_winc == w_wd) ? '0 : WA_BITS'(w_winc);
                r_win_fill <= (r_win_fill < w_wd) ? r_win_fill + 1'b1 : w_wd;
                r_fired    <= o_sts.fire;
                unique case (r_mode)
                    MODE_IDLE: begin
                        if (w_above) begin
                            r_run  <= 16'd1;
                            r_mode <= MODE_ARMED;
                        end
                    end
                    MODE_ARMED: begin
                        if (w_above) begin
                            r_run <= w_run_inc;
                            if (o_sts.fire) begin
                                r_mode <= MODE_REFR;
                                r_refr <= i_cfg.refr_samples;
                            end
                        end else begin
                            r_run  <= '0;
                            r_mode <= MODE_IDLE;
                        end
                    end
                    MODE_REFR: begin
                        if (r_refr != '0) begin
                            r_refr <= r_refr - 16'd1;
                        end else begin
                            r_settle <= '0;
                            r_mode   <= MODE_SETTLE;
                        end
                    end
                    MODE_SETTLE: begin
                        if (w_above) begin
                            r_settle <= '0;
                        end else begin
                            if (r_settle != 16'hFFFF) r_settle <= r_settle + 16'd1;
                            if (((r_settle == 16'hFFFF) ? r_settle : r_settle + 16'd1)
                                >= i_cfg.settle_samples) begin
                                r_mode <= MODE_IDLE;
                            end
                        end
                    end
                    default: r_mode <= MODE_IDLE;
                endcase
            end
        end
    end

    // Window scan for the peaks, newest entry first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_v <= 1'b0;
        end else begin
            r_cmp_v <= i_cmd.scan_rd;
        end
        if (i_cmd.diff) begin
            r_scan_p <= w_widx;
            r_scan_j <= '0;
            r_pk     <= '0;
            for (int i = 0; i < 4; i++) r_pch[i] <= '0;
        end
        if (i_cmd.scan_rd) begin
            r_scan_p <= (r_scan_p == '0) ? WA_BITS'(w_wd - 1'b1) : r_scan_p - 1'b1;
            r_scan_j <= r_scan_j + 1'b1;
        end
        if (r_cmp_v) begin
            if (w_rsmag > r_pk) r_pk <= w_rsmag;
            for (int i = 0; i < 4; i++) begin
                if (w_rcmag[i] > r_pch[i]) r_pch[i] <= w_rcmag[i];
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
        if (i_cmd.finish) begin
            o_hp_sum         <= 28'(r_sum);
            o_diff_sum       <= 29'(r_dsum);
            o_event_valid    <= r_fired;
            o_event_peak     <= r_fired ? r_pk : '0;
            o_peak_ch0       <= r_fired ? r_pch[0] : '0;
            o_peak_ch1       <= r_fired ? r_pch[1] : '0;
            o_peak_ch2       <= r_fired ? r_pch[2] : '0;
            o_peak_ch3       <= r_fired ? r_pch[3] : '0;
            o_event_time_ms  <= r_fired ? r_time : '0;
            o_detector_state <= r_mode;
        end
    end
endmodule

[hdl/impact_hit_detector_top.sv]
// Top level of the impact hit detector: register port, controller and datapath.
// Each sample is captured, loaded and differenced; a firing sample then scans the
// window for its peaks before the result register is written, once the output is free.
// A new sample is taken only after the last one has finished, and the single read
// port of the window memory paces the peak scan.
// Reset (i_rst_n low, synchronous) restores register defaults, clears baselines,
// pointers and detector state; the delay and window memories are not cleared.
`timescale 1ns / 1ps
module impact_hit_detector_top import ihd_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [4:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_ch0,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_ch1,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_ch2,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_ch3,
    input  logic [31:0]                 i_time_ms,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [27:0]          o_hp_sum,
    output logic signed [28:0]          o_diff_sum,
    output logic                        o_event_valid,
    output logic [28:0]                 o_event_peak,
    output logic [26:0]                 o_peak_ch0,
    output logic [26:0]                 o_peak_ch1,
    output logic [26:0]                 o_peak_ch2,
    output logic [26:0]                 o_peak_ch3,
    output logic [31:0]                 o_event_time_ms,
    output logic [1:0]                  o_detector_state
);
    logic [13:0] r_refr_ms;
    logic [25:0] r_refr_prod;
    t_cfg        r_cfg;
    t_cmd        w_cmd;
    t_sts        w_sts;
    logic        w_wr;
    logic [47:0] w_recip;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Refractory length in samples: ms * 3906 / 1000, as a multiply and a
    // reciprocal multiply by 1/125 after dropping three bits.
    assign w_recip = 48'(r_refr_prod[25:3]) * 48'(RECIP_125);

    // Configuration registers and the refractory length pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.baseline_shift <= 5'd13;
            r_cfg.hit_threshold  <= 29'd20000;
            r_cfg.min_duration   <= 16'd3;
            r_refr_ms            <= 14'd50;
            r_cfg.settle_samples <= 16'd32;
            r_cfg.diff_depth     <= 7'd16;
            r_cfg.window_depth   <= 7'd32;
            r_refr_prod          <= 26'd195300;
            r_cfg.refr_samples   <= 16'd195;
        end else begin
            r_refr_prod        <= 26'(r_refr_ms * 26'(REFR_MUL));
            r_cfg.refr_samples <= 16'(w_recip >> RECIP_SHIFT);
            if (w_wr) begin
                unique case (paddr[4:2])
                    REG_SHIFT:  r_cfg.baseline_shift <= pwdata[4:0];
                    REG_THRESH: r_cfg.hit_threshold  <= pwdata[28:0];
                    REG_MINDUR: r_cfg.min_duration   <= pwdata[15:0];
                    REG_REFR:   r_refr_ms            <= pwdata[13:0];
                    REG_SETTLE: r_cfg.settle_samples <= pwdata[15:0];
                    REG_DDEPTH: r_cfg.diff_depth     <= pwdata[6:0];
                    REG_WDEPTH: r_cfg.window_depth   <= pwdata[6:0];
                    default: ;
                endcase
            end
        end
    end

    // Register read back.
    always_comb begin
        unique case (paddr[4:2])
            REG_SHIFT:  prdata = 32'(r_cfg.baseline_shift);
            REG_THRESH: prdata = 32'(r_cfg.hit_threshold);
            REG_MINDUR: prdata = 32'(r_cfg.min_duration);
            REG_REFR:   prdata = 32'(r_refr_ms);
            REG_SETTLE: prdata = 32'(r_cfg.settle_samples);
            REG_DDEPTH: prdata = 32'(r_cfg.diff_depth);
            REG_WDEPTH: prdata = 32'(r_cfg.window_depth);
            default:    prdata = '0;
        endcase
    end

    ihd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ihd_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_sample_ch0     (i_sample_ch0),
        .i_sample_ch1     (i_sample_ch1),
        .i_sample_ch2     (i_sample_ch2),
        .i_sample_ch3     (i_sample_ch3),
        .i_time_ms        (i_time_ms),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_hp_sum         (o_hp_sum),
        .o_diff_sum       (o_diff_sum),
        .o_event_valid    (o_event_valid),
        .o_event_peak     (o_event_peak),
        .o_peak_ch0       (o_peak_ch0),
        .o_peak_ch1       (o_peak_ch1),
        .o_peak_ch2       (o_peak_ch2),
        .o_peak_ch3       (o_peak_ch3),
        .o_event_time_ms  (o_event_time_ms),
        .o_detector_state (o_detector_state)
    );

    // A taken word leaves the input side busy on the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again without processing");

    // A hit always leaves the detector in refractory.
    a_fire_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_valid) |-> (o_detector_state == MODE_REFR))
        else $error("hit reported outside refractory");

    // Without a hit the event fields read zero.
    a_no_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_event_valid) |-> (o_event_peak == '0 && o_event_time_ms == '0))
        else $error("event fields set without a hit");
endmodule
